FILE: rtl/core/stt_pkg.sv
package stt_pkg;

  // Field widths of the token stream
  localparam int OffsetBits   = 20;
  localparam int PositionBits = 16;
  localparam int KindBits     = 6;

  // A byte can raise at most this many tokens
  localparam int MaxTok = 3;

  // Default depth of the token queue (at least MaxTok + 1)
  localparam int TokFifoDepth = 4;

  typedef logic [OffsetBits-1:0]   offset_t;
  typedef logic [PositionBits-1:0] position_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic [KindBits-1:0] token_kind;
    position_t           line_no;
    position_t           column_no;
    offset_t             start_offset;
    offset_t             text_length;
    logic                run_end;
  } token_t;

  // Tokens raised by one byte, slot 0 first
  typedef struct packed {
    logic [1:0]        count;
    token_t [MaxTok-1:0] tok;
  } tok_batch_t;

  typedef enum logic [KindBits-1:0] {
    KindQuotes    = 6'd0,
    KindPeriod    = 6'd1,
    KindComma     = 6'd2,
    KindLParen    = 6'd3,
    KindRParen    = 6'd4,
    KindLSquare   = 6'd5,
    KindRSquare   = 6'd6,
    KindLCurly    = 6'd7,
    KindRCurly    = 6'd8,
    KindAssign    = 6'd9,
    KindSemicolon = 6'd10,
    KindPlus      = 6'd11,
    KindMinus     = 6'd12,
    KindMultiply  = 6'd13,
    KindDivide    = 6'd14,
    KindExponent  = 6'd15,
    KindModulo    = 6'd16,
    KindNot       = 6'd17,
    KindEq        = 6'd18,
    KindNotEq     = 6'd19,
    KindIncrement = 6'd20,
    KindLt        = 6'd21,
    KindLtEq      = 6'd22,
    KindGt        = 6'd23,
    KindGtEq      = 6'd24,
    KindIdent     = 6'd25,
    KindFunc      = 6'd26,
    KindVar       = 6'd27,
    KindReturn    = 6'd28,
    KindIf        = 6'd29,
    KindElse      = 6'd30,
    KindFor       = 6'd31,
    KindInt       = 6'd32,
    KindFloat     = 6'd33,
    KindString    = 6'd34,
    KindEof       = 6'd35
  } tok_kind_e;

  typedef enum logic [5:0] {
    ModeIdle  = 6'b000001,
    ModeOper  = 6'b000010,
    ModeWord  = 6'b000100,
    ModeInt   = 6'b001000,
    ModeFloat = 6'b010000,
    ModeStr   = 6'b100000
  } scan_mode_e;

  // Keywords, right-aligned in the 48-bit window of recent word chars
  localparam logic [47:0] KwFunc   = 48'h0000_6675_6E63;
  localparam logic [47:0] KwVar    = 48'h0000_0076_6172;
  localparam logic [47:0] KwReturn = 48'h7265_7475_726E;
  localparam logic [47:0] KwIf     = 48'h0000_0000_6966;
  localparam logic [47:0] KwElse   = 48'h0000_656C_7365;
  localparam logic [47:0] KwFor    = 48'h0000_0066_6F72;

  function automatic position_t sat_inc(position_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic is_word_char(logic [7:0] b);
    return (b inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || (b == 8'h5F);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_oper(logic [7:0] b);
    return b inside {8'h3D, 8'h21, 8'h3C, 8'h3E, 8'h2B};
  endfunction

  function automatic logic is_single(logic [7:0] b);
    return b inside {8'h2E, 8'h2C, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D,
                     8'h3B, 8'h2D, 8'h2A, 8'h2F, 8'h5E, 8'h25};
  endfunction

  function automatic tok_kind_e single_kind(logic [7:0] b);
    tok_kind_e k;
    case (b)
      8'h2E:   k = KindPeriod;
      8'h2C:   k = KindComma;
      8'h28:   k = KindLParen;
      8'h29:   k = KindRParen;
      8'h5B:   k = KindLSquare;
      8'h5D:   k = KindRSquare;
      8'h7B:   k = KindLCurly;
      8'h7D:   k = KindRCurly;
      8'h3B:   k = KindSemicolon;
      8'h2D:   k = KindMinus;
      8'h2A:   k = KindMultiply;
      8'h2F:   k = KindDivide;
      8'h5E:   k = KindExponent;
      default: k = KindModulo;
    endcase
    return k;
  endfunction

  function automatic tok_kind_e oper_kind(logic [7:0] op, logic two);
    tok_kind_e k;
    case (op)
      8'h3D:   k = two ? KindEq    : KindAssign;
      8'h21:   k = two ? KindNotEq : KindNot;
      8'h3C:   k = two ? KindLtEq  : KindLt;
      8'h3E:   k = two ? KindGtEq  : KindGt;
      default: k = two ? KindIncrement : KindPlus;
    endcase
    return k;
  endfunction

  function automatic tok_kind_e word_kind(logic [47:0] win, logic too_long);
    tok_kind_e k;
    if (too_long)            k = KindIdent;
    else if (win == KwFunc)   k = KindFunc;
    else if (win == KwVar)    k = KindVar;
    else if (win == KwReturn) k = KindReturn;
    else if (win == KwIf)     k = KindIf;
    else if (win == KwElse)   k = KindElse;
    else if (win == KwFor)    k = KindFor;
    else                      k = KindIdent;
    return k;
  endfunction

  function automatic token_t make_tok(tok_kind_e k, position_t line, position_t col,
                                      offset_t start, offset_t len);
    token_t t;
    t.token_kind   = k;
    t.line_no      = line;
    t.column_no    = col;
    t.start_offset = start;
    t.text_length  = len;
    t.run_end      = 1'b0;
    return t;
  endfunction

endpackage

FILE: rtl/core/stt_scanner.sv
module stt_scanner (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  stt_pkg::in_item_t  item_i,
  output stt_pkg::tok_batch_t batch_o
);
  import stt_pkg::*;

  // Scanner state
  scan_mode_e  mode_q, mode_d;
  logic [7:0]  op_q, op_d;
  logic [47:0] win_q, win_d;
  logic        tl_q, tl_d;
  offset_t     ts_q, ts_d;
  offset_t     pos_q, pos_d;
  position_t   line_q, line_d;
  position_t   col_q, col_d;

  logic [7:0]  b;
  logic        fin;
  offset_t     nxt;
  logic        done;
  logic [1:0]  n;
  token_t [MaxTok-1:0] toks;

  assign b   = item_i.text_byte;
  assign fin = item_i.is_final;
  assign nxt = pos_q + 1'b1;

  // One byte step: close or extend the open token, then start a new one
  always_comb begin
    mode_d = mode_q;
    op_d   = op_q;
    win_d  = win_q;
    tl_d   = tl_q;
    ts_d   = ts_q;
    line_d = line_q;
    col_d  = col_q;
    pos_d  = nxt;
    done   = 1'b0;
    n      = 2'd0;
    toks   = '0;

    case (mode_q)
      ModeOper: begin
        if (b == 8'h3D) begin
          toks[n] = make_tok(oper_kind(op_q, 1'b1), line_d, col_d, ts_q, '0);
          n       = n + 2'd1;
          col_d   = sat_inc(sat_inc(col_d));
          done    = 1'b1;
        end else begin
          toks[n] = make_tok(oper_kind(op_q, 1'b0), line_d, col_d, ts_q, '0);
          n       = n + 2'd1;
          col_d   = sat_inc(col_d);
        end
        mode_d = ModeIdle;
        op_d   = '0;
      end
      ModeWord: begin
        if (is_word_char(b)) begin
          if (win_q[47:40] != 8'h00) tl_d = 1'b1;
          win_d = {win_q[39:0], b};
          col_d = sat_inc(col_d);
          done  = 1'b1;
        end else begin
          toks[n] = make_tok(word_kind(win_q, tl_q), line_d, col_d, ts_q, pos_q - ts_q);
          n       = n + 2'd1;
          mode_d  = ModeIdle;
        end
      end
      ModeInt, ModeFloat: begin
        if (is_digit(b)) begin
          col_d = sat_inc(col_d);
          done  = 1'b1;
        end else if (b == 8'h2E && mode_q == ModeInt) begin
          col_d  = sat_inc(col_d);
          mode_d = ModeFloat;
          done   = 1'b1;
        end else begin
          toks[n] = make_tok((mode_q == ModeInt) ? KindInt : KindFloat,
                             line_d, col_d, ts_q, pos_q - ts_q);
          n       = n + 2'd1;
          mode_d  = ModeIdle;
        end
      end
      ModeStr: begin
        if (b == 8'h22) begin
          toks[n] = make_tok(KindString, line_d, col_d, ts_q, pos_q - ts_q);
          n       = n + 2'd1;
          col_d   = sat_inc(col_d);
          toks[n] = make_tok(KindQuotes, line_d, col_d, pos_q, '0);
          n       = n + 2'd1;
          mode_d  = ModeIdle;
        end else begin
          col_d = sat_inc(col_d);
        end
        done = 1'b1;
      end
      default: begin
        mode_d = ModeIdle;
      end
    endcase

    // Byte not taken by an open token
    if (!done) begin
      if (is_single(b)) begin
        toks[n] = make_tok(single_kind(b), line_d, col_d, pos_q, '0);
        n       = n + 2'd1;
        col_d   = sat_inc(col_d);
      end else if (b == 8'h22) begin
        toks[n] = make_tok(KindQuotes, line_d, col_d, pos_q, '0);
        n       = n + 2'd1;
        col_d   = sat_inc(col_d);
        mode_d  = ModeStr;
        ts_d    = nxt;
      end else if (is_oper(b)) begin
        mode_d = ModeOper;
        op_d   = b;
        ts_d   = pos_q;
      end else if (b == 8'h0A) begin
        line_d = sat_inc(line_d);
        col_d  = position_t'(1);
      end else if (is_word_char(b)) begin
        mode_d = ModeWord;
        ts_d   = pos_q;
        win_d  = {40'd0, b};
        tl_d   = 1'b0;
        col_d  = sat_inc(col_d);
      end else if (is_digit(b)) begin
        mode_d = ModeInt;
        ts_d   = pos_q;
        col_d  = sat_inc(col_d);
      end else begin
        // space, tab and unknown bytes
        col_d = sat_inc(col_d);
      end
    end

    // Last byte: flush the open token, add the end token, start over
    if (fin) begin
      if (mode_d == ModeOper) begin
        toks[n] = make_tok(oper_kind(op_d, 1'b0), line_d, col_d, ts_d, '0);
        n       = n + 2'd1;
        col_d   = sat_inc(col_d);
      end else if (mode_d == ModeWord) begin
        toks[n] = make_tok(word_kind(win_d, tl_d), line_d, col_d, ts_d, nxt - ts_d);
        n       = n + 2'd1;
      end else if (mode_d == ModeInt || mode_d == ModeFloat) begin
        toks[n] = make_tok((mode_d == ModeInt) ? KindInt : KindFloat,
                           line_d, col_d, ts_d, nxt - ts_d);
        n       = n + 2'd1;
      end else if (mode_d == ModeStr && nxt != ts_d) begin
        toks[n] = make_tok(KindString, line_d, col_d, ts_d, nxt - ts_d);
        n       = n + 2'd1;
      end
      toks[n] = make_tok(KindEof, line_d, col_d, nxt, '0);
      n       = n + 2'd1;
      mode_d  = ModeIdle;
      op_d    = '0;
      win_d   = '0;
      tl_d    = 1'b0;
      ts_d    = '0;
      pos_d   = '0;
      line_d  = position_t'(1);
      col_d   = position_t'(1);
    end

    if (n != 2'd0) toks[n - 2'd1].run_end = 1'b1;
  end

  assign batch_o.count = step_i ? n : 2'd0;
  assign batch_o.tok   = toks;

  // State registers, updated per processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      op_q   <= '0;
      win_q  <= '0;
      tl_q   <= 1'b0;
      ts_q   <= '0;
      pos_q  <= '0;
      line_q <= position_t'(1);
      col_q  <= position_t'(1);
    end else if (step_i) begin
      mode_q <= mode_d;
      op_q   <= op_d;
      win_q  <= win_d;
      tl_q   <= tl_d;
      ts_q   <= ts_d;
      pos_q  <= pos_d;
      line_q <= line_d;
      col_q  <= col_d;
    end
  end

`ifndef NO_ASSERTIONS
  // the last byte leaves the scanner as after reset
  a_final_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && fin |=> mode_q == ModeIdle && pos_q == '0 && line_q == position_t'(1)
                      && col_q == position_t'(1))
    else $error("scanner not restarted after last byte");

  // the last byte always ends in an end token
  a_final_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && fin |-> batch_o.count != 2'd0
                      && batch_o.tok[batch_o.count - 2'd1].token_kind == KindEof)
    else $error("no end token after last byte");

  // the last token of a batch closes the run
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    batch_o.count != 2'd0 |-> batch_o.tok[batch_o.count - 2'd1].run_end)
    else $error("run_end missing on last token of a byte");
`endif

endmodule

FILE: rtl/core/stt_token_fifo.sv
module stt_token_fifo #(
  parameter int Depth = stt_pkg::TokFifoDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stt_pkg::tok_batch_t batch_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output stt_pkg::token_t     out_data_o
);
  import stt_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  token_t          mem [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW-1:0] w1, w2, w3;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign w1 = ptr_inc(wr_q);
  assign w2 = ptr_inc(w1);
  assign w3 = ptr_inc(w2);

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = count_q != '0;
  assign out_data_o  = mem[rd_q];
  // room for a full batch of tokens
  assign room_o      = count_q <= CntW'(Depth - MaxTok);

  // Pointer and fill bookkeeping
  always_comb begin
    case (batch_i.count)
      2'd0:    wr_d = wr_q;
      2'd1:    wr_d = w1;
      2'd2:    wr_d = w2;
      default: wr_d = w3;
    endcase
    rd_d    = pop ? ptr_inc(rd_q) : rd_q;
    count_d = count_q + CntW'(batch_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // Token storage, up to three writes per cycle
  always_ff @(posedge clk_i) begin
    if (batch_i.count != 2'd0) mem[wr_q] <= batch_i.tok[0];
    if (batch_i.count >= 2'd2) mem[w1]   <= batch_i.tok[1];
    if (batch_i.count == 2'd3) mem[w2]   <= batch_i.tok[2];
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("token queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    batch_i.count != 2'd0 |-> room_o)
    else $error("tokens pushed without room");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && batch_i.count == 2'd0 |=> count_q == $past(count_q) - 1'b1)
    else $error("fill count wrong after transfer");
`endif

endmodule

FILE: rtl/core/source_text_tokenizer_top.sv
// Source text tokenizer: one byte per input transfer, one token per output transfer.
// A token passes the input register and the token queue before it can be taken.
// Throughput: one byte per cycle while bytes raise at most one token each and the
// sink takes every token; the single output port moves one token per cycle, so the
// extra tokens of a byte raising 2 or 3 wait in the token queue.
// Reset: asynchronous, active low; scanner state back to line 1, column 1, offset 0.
module source_text_tokenizer_top #(
  parameter int TokFifoDepth = stt_pkg::TokFifoDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  stt_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output stt_pkg::token_t   out_data_o
);
  import stt_pkg::*;

  in_item_t   in_q;
  logic       in_valid_q;
  logic       room;
  logic       step;
  tok_batch_t batch;

  // Input register, drained when the queue can take a full batch
  assign step       = in_valid_q && room;
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  stt_scanner u_scanner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (in_q),
    .batch_o (batch)
  );

  stt_token_fifo #(
    .Depth (TokFifoDepth)
  ) u_token_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .batch_i     (batch),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: dv/token_stream_checker.sv
`timescale 1ns / 100ps

module token_stream_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  stt_pkg::in_item_t in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  stt_pkg::token_t   out_data_i,
  output int                error_count_o,
  output int                due_count_o,
  output int                bytes_seen_o,
  output int                tokens_seen_o,
  output logic [35:0]       kinds_seen_o
);
  import stt_pkg::*;

  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChEquals  = 8'h3D;
  localparam logic [7:0] ChPeriod  = 8'h2E;

  // Keywords as they sit right-aligned in the window of recent word chars
  localparam logic [47:0] WinFunc   = "func";
  localparam logic [47:0] WinVar    = "var";
  localparam logic [47:0] WinReturn = "return";
  localparam logic [47:0] WinIf     = "if";
  localparam logic [47:0] WinElse   = "else";
  localparam logic [47:0] WinFor    = "for";

  // Scanner state, tracked from the accepted byte stream
  scan_mode_e  mode_q;
  logic [7:0]  op_q;
  logic [47:0] win_q;
  logic        long_q;
  offset_t     start_q;
  offset_t     pos_q;
  position_t   line_q;
  position_t   col_q;

  // Tokens raised by the current byte, then the queue still owed by the block
  token_t batch [3];
  int     batch_n;
  token_t tokens_due [$];

  function automatic position_t sat_up(position_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic letter_like(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic digit_like(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic tok_kind_e word_class(logic [47:0] w, logic too_long);
    if (too_long) return KindIdent;
    case (w)
      WinFunc:   return KindFunc;
      WinVar:    return KindVar;
      WinReturn: return KindReturn;
      WinIf:     return KindIf;
      WinElse:   return KindElse;
      WinFor:    return KindFor;
      default:   return KindIdent;
    endcase
  endfunction

  // one- or two-char form of a pending operator
  function automatic tok_kind_e pair_kind(logic [7:0] op, logic two);
    case (op)
      "=":     return two ? KindEq : KindAssign;
      "!":     return two ? KindNotEq : KindNot;
      "<":     return two ? KindLtEq : KindLt;
      ">":     return two ? KindGtEq : KindGt;
      default: return two ? KindIncrement : KindPlus;
    endcase
  endfunction

  function automatic logic punct_kind(logic [7:0] b, output tok_kind_e k);
    logic hit;
    hit = 1'b1;
    k   = KindPeriod;
    case (b)
      ".":     k = KindPeriod;
      ",":     k = KindComma;
      "(":     k = KindLParen;
      ")":     k = KindRParen;
      "[":     k = KindLSquare;
      "]":     k = KindRSquare;
      "{":     k = KindLCurly;
      "}":     k = KindRCurly;
      ";":     k = KindSemicolon;
      "-":     k = KindMinus;
      "*":     k = KindMultiply;
      "/":     k = KindDivide;
      "^":     k = KindExponent;
      "%":     k = KindModulo;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  task automatic restart_scan();
    mode_q  = ModeIdle;
    op_q    = '0;
    win_q   = '0;
    long_q  = 1'b0;
    start_q = '0;
    pos_q   = '0;
    line_q  = position_t'(1);
    col_q   = position_t'(1);
  endtask

  // stamps a token with the current line and column
  task automatic note_token(tok_kind_e kind, offset_t start, offset_t len);
    token_t t;
    t.token_kind   = kind;
    t.line_no      = line_q;
    t.column_no    = col_q;
    t.start_offset = start;
    t.text_length  = len;
    t.run_end      = 1'b0;
    if (batch_n < 3) batch[batch_n] = t;
    batch_n++;
  endtask

  // closes an open word or number whose text ends at stop
  task automatic close_text(offset_t stop);
    offset_t len;
    len = stop - start_q;
    case (mode_q)
      ModeWord: note_token(word_class(win_q, long_q), start_q, len);
      ModeInt:  note_token(KindInt, start_q, len);
      default:  note_token(KindFloat, start_q, len);
    endcase
    mode_q = ModeIdle;
  endtask

  task automatic predict_tokens(logic [7:0] b, logic fin);
    offset_t   here;
    offset_t   nxt;
    logic      taken;
    tok_kind_e k;
    token_t    t;
    here    = pos_q;
    nxt     = pos_q + 1'b1;
    taken   = 1'b0;
    batch_n = 0;

    // finish or extend whatever token is open
    case (mode_q)
      ModeOper: begin
        if (b == ChEquals) begin
          note_token(pair_kind(op_q, 1'b1), start_q, '0);
          col_q = sat_up(sat_up(col_q));
          taken = 1'b1;
        end else begin
          note_token(pair_kind(op_q, 1'b0), start_q, '0);
          col_q = sat_up(col_q);
        end
        mode_q = ModeIdle;
        op_q   = '0;
      end
      ModeWord: begin
        if (letter_like(b)) begin
          if (win_q[47:40] != '0) long_q = 1'b1;
          win_q = {win_q[39:0], b};
          col_q = sat_up(col_q);
          taken = 1'b1;
        end else begin
          close_text(here);
        end
      end
      ModeInt, ModeFloat: begin
        if (digit_like(b)) begin
          col_q = sat_up(col_q);
          taken = 1'b1;
        end else if (b == ChPeriod && mode_q == ModeInt) begin
          col_q  = sat_up(col_q);
          mode_q = ModeFloat;
          taken  = 1'b1;
        end else begin
          close_text(here);
        end
      end
      ModeStr: begin
        if (b == ChQuote) begin
          note_token(KindString, start_q, here - start_q);
          col_q = sat_up(col_q);
          note_token(KindQuotes, here, '0);
          mode_q = ModeIdle;
        end else begin
          col_q = sat_up(col_q);
        end
        taken = 1'b1;
      end
      default: mode_q = ModeIdle;
    endcase

    // a byte not absorbed above starts something new or is skipped
    if (!taken) begin
      if (punct_kind(b, k)) begin
        note_token(k, here, '0);
        col_q = sat_up(col_q);
      end else if (b == ChQuote) begin
        note_token(KindQuotes, here, '0);
        col_q   = sat_up(col_q);
        mode_q  = ModeStr;
        start_q = nxt;
      end else if (b == "=" || b == "!" || b == "<" || b == ">" || b == "+") begin
        mode_q  = ModeOper;
        op_q    = b;
        start_q = here;
      end else if (b == ChNewline) begin
        line_q = sat_up(line_q);
        col_q  = position_t'(1);
      end else if (letter_like(b)) begin
        mode_q  = ModeWord;
        start_q = here;
        win_q   = {40'h0, b};
        long_q  = 1'b0;
        col_q   = sat_up(col_q);
      end else if (digit_like(b)) begin
        mode_q  = ModeInt;
        start_q = here;
        col_q   = sat_up(col_q);
      end else begin
        col_q = sat_up(col_q);
      end
    end

    pos_q = nxt;

    // last byte: flush the open token, add end of input, start afresh
    if (fin) begin
      case (mode_q)
        ModeOper: begin
          note_token(pair_kind(op_q, 1'b0), start_q, '0);
          col_q = sat_up(col_q);
        end
        ModeWord, ModeInt, ModeFloat: close_text(nxt);
        ModeStr: if (nxt != start_q) note_token(KindString, start_q, nxt - start_q);
        default: ;
      endcase
      note_token(KindEof, nxt, '0);
      restart_scan();
    end

    for (int i = 0; i < batch_n && i < 3; i++) begin
      t         = batch[i];
      t.run_end = (i == batch_n - 1);
      tokens_due.push_back(t);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_p
    token_t want;
    token_t got;
    int     bad;
    if (!rst_ni) begin
      restart_scan();
      tokens_due.delete();
      batch_n       = 0;
      error_count_o <= 0;
      due_count_o   <= 0;
      bytes_seen_o  <= 0;
      tokens_seen_o <= 0;
      kinds_seen_o  <= '0;
    end else begin
      bad = 0;
      // input transfer: work out the tokens it owes
      if (in_valid_i && in_ready_i) begin
        predict_tokens(in_data_i.text_byte, in_data_i.is_final);
        bytes_seen_o <= bytes_seen_o + 1;
      end
      // output transfer: compare with the oldest token due
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        tokens_seen_o <= tokens_seen_o + 1;
        if (tokens_due.size() == 0) begin
          $error("token kind %0d at offset %0d with none due", got.token_kind,
                 got.start_offset);
          bad++;
        end else begin
          want = tokens_due.pop_front();
          kinds_seen_o[want.token_kind] <= 1'b1;
          if (got.token_kind !== want.token_kind) begin
            $error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
            bad++;
          end
          if (got.line_no !== want.line_no) begin
            $error("line_no: expected %0d, got %0d", want.line_no, got.line_no);
            bad++;
          end
          if (got.column_no !== want.column_no) begin
            $error("column_no: expected %0d, got %0d", want.column_no, got.column_no);
            bad++;
          end
          if (got.start_offset !== want.start_offset) begin
            $error("start_offset: expected %0d, got %0d", want.start_offset,
                   got.start_offset);
            bad++;
          end
          if (got.text_length !== want.text_length) begin
            $error("text_length: expected %0d, got %0d", want.text_length,
                   got.text_length);
            bad++;
          end
          if (got.run_end !== want.run_end) begin
            $error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
            bad++;
          end
        end
      end
      error_count_o <= error_count_o + bad;
      due_count_o   <= tokens_due.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import stt_pkg::*;

  localparam int CycleLimit  = 800000;
  localparam int DrainCycles = 10;
  localparam int RandomBytes = 200;
  localparam int HoldCycles  = 150;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_item_t in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  token_t   out_data;

  int          error_count;
  int          due_count;
  int          bytes_seen;
  int          tokens_seen;
  logic [35:0] kinds_seen;

  int   cycle_count = 0;
  int   hold_reqs   = 0;
  logic tx_steady   = 1'b0;
  logic rx_steady   = 1'b0;

  logic [7:0] text_q [$];
  int         bytes_random;

  always #2 clk = ~clk;

  source_text_tokenizer_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  token_stream_checker token_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .error_count_o (error_count),
    .due_count_o   (due_count),
    .bytes_seen_o  (bytes_seen),
    .tokens_seen_o (tokens_seen),
    .kinds_seen_o  (kinds_seen)
  );

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $error("run stopped after %0d cycles, %0d tokens still due", cycle_count, due_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Token sink: random stalls, steady stretches, and a long hold-off on request
  initial begin : sink_p
    int stall_left;
    int holds_done;
    int r;
    stall_left = 0;
    holds_done = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (holds_done != hold_reqs) begin
        holds_done = hold_reqs;
        stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (rx_steady) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end
      end
    end
  end

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + r - 26);
    return "_";
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_byte(logic [7:0] b, logic fin);
    in_item_t item;
    int       gap;
    gap            = pick_gap();
    item.text_byte = b;
    item.is_final  = fin;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // sender stays quiet until the block owes nothing
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (due_count != 0);
  endtask

  // mostly well-formed lexemes with random content, plus some stray bytes
  task automatic build_random_text();
    string      keywords [6];
    string      puncts;
    string      opers;
    int         n_lex;
    int         len;
    int         r;
    logic [7:0] c;
    keywords = '{"func", "var", "return", "if", "else", "for"};
    puncts   = ".,()[]{};-*/^%";
    opers    = "=!<>+";
    n_lex    = $urandom_range(1, 12);
    for (int i = 0; i < n_lex; i++) begin
      case ($urandom_range(0, 8))
        0: add_str(keywords[$urandom_range(0, 5)]);
        1: begin
          len = $urandom_range(1, 9);
          for (int j = 0; j < len; j++) text_q.push_back(rand_letter());
        end
        2: begin
          len = $urandom_range(1, 5);
          for (int j = 0; j < len; j++) text_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
        end
        3: begin
          text_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
          text_q.push_back(".");
          len = $urandom_range(0, 3);
          for (int j = 0; j < len; j++) text_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
          if ($urandom_range(0, 5) == 0) text_q.push_back(".");
        end
        4: begin
          text_q.push_back(8'h22);
          len = $urandom_range(0, 6);
          for (int j = 0; j < len; j++) begin
            r = $urandom_range(0, 99);
            if (r < 60) c = rand_letter();
            else if (r < 75) c = 8'h0A;
            else c = 8'($urandom_range(0, 255));
            if (c == 8'h22) c = 8'h27;
            text_q.push_back(c);
          end
          if ($urandom_range(0, 6) != 0) text_q.push_back(8'h22);
        end
        5: text_q.push_back(puncts[$urandom_range(0, 13)]);
        6: begin
          text_q.push_back(opers[$urandom_range(0, 4)]);
          if ($urandom_range(0, 1) == 1) text_q.push_back("=");
        end
        7: begin
          len = $urandom_range(1, 3);
          for (int j = 0; j < len; j++) begin
            r = $urandom_range(0, 2);
            text_q.push_back(r == 0 ? 8'h20 : (r == 1 ? 8'h09 : 8'h0A));
          end
        end
        default: text_q.push_back(8'($urandom_range(0, 255)));
      endcase
      if ($urandom_range(0, 9) < 4) text_q.push_back($urandom_range(0, 3) == 0 ? 8'h0A : 8'h20);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed texts
    // keyword, two-char operator, decimal left open at the end
    add_str("if+=2.5");
    send_text();
    // string with a newline inside, then a lone operator flushed at the end
    add_str("\"q\n\"!");
    send_text();
    // unknown bytes at both ends of the byte range are skipped
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    send_text();
    // a string opened on the last byte has no text to flush
    add_str("\"");
    send_text();
    // over-long word ending in a keyword, then a digit that starts an integer
    add_str("xreturn9");
    send_text();

    // Long sink hold-off while bytes keep coming, then a full drain
    hold_reqs++;
    tx_steady = 1'b1;
    add_str("(){}[];,.-*/^%(){}[];,.");
    send_text();
    wait_drained();

    // Random texts
    bytes_random = 0;
    while (bytes_random < RandomBytes) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      build_random_text();
      bytes_random += text_q.size();
      send_text();
      if ($urandom_range(0, 4) == 0) wait_drained();
    end

    // Let every owed token arrive, then settle
    in_valid <= 1'b0;
    do @(negedge clk); while (due_count != 0);
    repeat (DrainCycles) @(negedge clk);

    $display("Summary: %0d bytes in, %0d tokens out, %0d of 36 token kinds seen",
             bytes_seen, tokens_seen, $countones(kinds_seen));
    $display("Covered: directed and random texts, long sink hold-off, %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/stt_pkg.sv
rtl/core/stt_scanner.sv
rtl/core/stt_token_fifo.sv
rtl/core/source_text_tokenizer_top.sv
dv/token_stream_checker.sv
dv/tb_top.sv
